FILE: sv/huffman_tree_build_and_code_unit_defines.svh
// Assertion macros for the Huffman code unit checker.
// No dependencies; include by bare file name.
`ifndef HUFFMAN_TREE_BUILD_AND_CODE_UNIT_DEFINES_SVH
`define HUFFMAN_TREE_BUILD_AND_CODE_UNIT_DEFINES_SVH

// same-cycle implication
`define HFC_ASSERT_NOW(lbl, ant, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define HFC_ASSERT_NEXT(lbl, ant, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: sv/hfc_pkg.sv
// Package for the Huffman code unit: types, codes and constants.
// No dependencies.
`timescale 1ns / 1ps
package hfc_pkg;
    localparam int MAX_SYMBOLS_DEF = 256;
    localparam int WEIGHT_BITS_DEF = 24;
    localparam int NODE_W          = 32;
    localparam int CODE_BITS       = 255;
    localparam int LEN_BITS        = 8;

    typedef enum logic {CMD_LOAD = 1'b0, CMD_QUERY = 1'b1} t_cmd;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FEW  = 2'd1,
        ST_MANY = 2'd2,
        ST_BADQ = 2'd3
    } t_status;

    typedef struct packed {
        t_cmd        cmd;
        logic [23:0] weight;
        logic        last;
        logic [7:0]  symbol;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [7:0]  code_length;
        logic [63:0] code_bits_0;
        logic [63:0] code_bits_1;
        logic [63:0] code_bits_2;
        logic [63:0] code_bits_3;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE, S_CLR, S_SCAN, S_WR1, S_WR2, S_WALK_RD, S_WALK_CHK, S_WALK_BIT, S_DONE
    } t_state;

    typedef struct packed {
        logic clr;
        logic ev;
    } t_min2_ctl;
endpackage

FILE: sv/huffman_tree_build_and_code_unit.sv
// Huffman code unit top level: weight loading, tree build and code lookup.
// Depends on hfc_pkg, hfc_ram, hfc_min2.
//
// Usage: send load transactions (cmd 0) with one weight each, in symbol order;
// the one marked last closes the set, builds the tree and returns one status
// result (ok, fewer than two symbols, too many). A load after a closed set
// starts a new one. A query (cmd 1) returns the code length and code bits of a
// symbol, bit k being the branch at depth k below the root (0 left, 1 right);
// bad queries return status 3. The build first clears the parent links of
// nodes 1..2n-1, then runs n-1 merge steps; the step that makes node i scans
// nodes 1..i-1 through the single shared two-minimum compare unit, one node
// per cycle through the registered RAM read, then writes back the merged
// node in states S_WR1 and S_WR2. A query walks parent links from the leaf
// through the parent/right memories, one tree level per S_WALK_CHK and
// S_WALK_BIT pass. The input is held off (o_in_stall) while a build or walk
// runs; a finished result sits in the output register, and the next
// transaction is taken while it waits.
`timescale 1ns / 1ps
module huffman_tree_build_and_code_unit #(
    parameter int MAX_SYMBOLS = hfc_pkg::MAX_SYMBOLS_DEF,
    parameter int WEIGHT_BITS = hfc_pkg::WEIGHT_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  hfc_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output hfc_pkg::t_out_item o_out
);
    import hfc_pkg::*;

    localparam int DEPTH = 2 * MAX_SYMBOLS;
    localparam int IB    = $clog2(DEPTH);          // node index
    localparam int CB    = $clog2(MAX_SYMBOLS + 2); // count, holds MAX+1

    t_state r_state, n_state;

    logic [CB-1:0]        r_count, n_count;
    logic                 r_ready, n_ready;
    logic                 r_closed, n_closed;
    logic [IB-1:0]        r_i, n_i, r_j, n_j, r_evj, r_p, n_p, r_up, n_up;
    logic                 r_ev, n_ev;
    logic [LEN_BITS-1:0]  r_len, n_len;
    logic [CODE_BITS-1:0] r_code, n_code;
    t_out_item            r_res, n_res, r_out;
    logic                 r_out_vld;

    // memory ports
    logic              w_we, p_we, rt_we;
    logic [IB-1:0]     w_waddr, w_raddr, p_waddr, p_raddr, rt_waddr, rt_raddr;
    logic [NODE_W-1:0] w_wdata, w_rdata;
    logic [IB-1:0]     p_wdata, p_rdata, rt_wdata, rt_rdata;

    t_min2_ctl         mctl;
    logic [IB-1:0]     m_a, m_b;
    logic [NODE_W-1:0] m_wa, m_wb;

    logic          acc_in, out_free;
    logic [CB-1:0] cnt_eff, cnt_new;
    logic [IB-1:0] m_top, n_plus1;

    assign acc_in   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_vld || !i_out_stall;
    assign cnt_eff  = r_closed ? '0 : r_count;
    assign cnt_new  = (cnt_eff < CB'(MAX_SYMBOLS)) ? cnt_eff + CB'(1) : CB'(MAX_SYMBOLS + 1);
    assign m_top    = IB'({r_count, 1'b0} - (CB + 1)'(1));
    assign n_plus1  = IB'(r_count) + IB'(1);

    hfc_ram #(.W(NODE_W), .DEPTH(DEPTH)) u_weight (
        .i_clk, .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_raddr), .o_rdata(w_rdata)
    );
    hfc_ram #(.W(IB), .DEPTH(DEPTH)) u_parent (
        .i_clk, .i_we(p_we), .i_waddr(p_waddr), .i_wdata(p_wdata),
        .i_raddr(p_raddr), .o_rdata(p_rdata)
    );
    hfc_ram #(.W(IB), .DEPTH(DEPTH)) u_right (
        .i_clk, .i_we(rt_we), .i_waddr(rt_waddr), .i_wdata(rt_wdata),
        .i_raddr(rt_raddr), .o_rdata(rt_rdata)
    );

    hfc_min2 #(.IDX_BITS(IB)) u_min2 (
        .i_clk, .i_rst_n, .i_ctl(mctl), .i_idx(r_evj), .i_weight(w_rdata),
        .o_a(m_a), .o_b(m_b), .o_wa(m_wa), .o_wb(m_wb)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (acc_in) begin
                    if (i_in.cmd == CMD_QUERY) begin
                        if (r_ready && (9'(i_in.symbol) < 9'(r_count))) n_state = S_WALK_RD;
                        else n_state = S_DONE;
                    end else if (i_in.last) begin
                        if (cnt_new < CB'(2) || cnt_new > CB'(MAX_SYMBOLS)) n_state = S_DONE;
                        else n_state = S_CLR;
                    end
                end
            end
            S_CLR:      if (r_j == m_top) n_state = S_SCAN;
            S_SCAN:     if (!(r_j < r_i) && !r_ev) n_state = S_WR1;
            S_WR1:      n_state = S_WR2;
            S_WR2:      n_state = (r_i == m_top) ? S_DONE : S_SCAN;
            S_WALK_RD:  n_state = S_WALK_CHK;
            S_WALK_CHK: begin
                if (p_rdata == '0 || r_len == LEN_BITS'(CODE_BITS)) n_state = S_DONE;
                else n_state = S_WALK_BIT;
            end
            S_WALK_BIT: n_state = S_WALK_CHK;
            S_DONE:     if (out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_count  = r_count;
        n_ready  = r_ready;
        n_closed = r_closed;
        n_i      = r_i;
        n_j      = r_j;
        n_ev     = 1'b0;
        n_p      = r_p;
        n_up     = r_up;
        n_len    = r_len;
        n_code   = r_code;
        n_res    = r_res;
        mctl     = '0;
        w_we     = 1'b0;
        w_waddr  = IB'(cnt_eff) + IB'(1);
        w_wdata  = NODE_W'(i_in.weight[WEIGHT_BITS-1:0]);
        w_raddr  = r_j;
        p_we     = 1'b0;
        p_waddr  = r_j;
        p_wdata  = '0;
        p_raddr  = r_j;
        rt_we    = 1'b0;
        rt_waddr = r_i;
        rt_wdata = m_b;
        rt_raddr = p_rdata;
        unique case (r_state)
            S_IDLE: begin
                if (acc_in) begin
                    n_res = '0;
                    if (i_in.cmd == CMD_QUERY) begin
                        n_res.status = ST_BADQ;
                        n_p          = IB'(9'(i_in.symbol) + 9'd1);
                        n_len        = '0;
                        n_code       = '0;
                        if (r_ready && (9'(i_in.symbol) < 9'(r_count))) n_res.status = ST_OK;
                    end else begin
                        n_ready = 1'b0;
                        n_count = cnt_new;
                        w_we    = cnt_eff < CB'(MAX_SYMBOLS);
                        n_closed = i_in.last;
                        n_j      = IB'(1);
                        if (cnt_new < CB'(2)) n_res.status = ST_FEW;
                        else if (cnt_new > CB'(MAX_SYMBOLS)) n_res.status = ST_MANY;
                        else n_res.status = ST_OK;
                    end
                end
            end
            S_CLR: begin
                p_we = 1'b1;
                n_j  = r_j + IB'(1);
                if (r_j == m_top) begin
                    n_i      = n_plus1;
                    n_j      = IB'(1);
                    mctl.clr = 1'b1;
                end
            end
            S_SCAN: begin
                if (r_j < r_i) begin
                    n_j  = r_j + IB'(1);
                    n_ev = 1'b1;
                end
                mctl.ev = r_ev && (p_rdata == '0);
            end
            S_WR1: begin
                p_we    = 1'b1;
                p_waddr = m_a;
                p_wdata = r_i;
                rt_we   = 1'b1;
                w_we    = 1'b1;
                w_waddr = r_i;
                w_wdata = m_wa + m_wb;
            end
            S_WR2: begin
                p_we    = 1'b1;
                p_waddr = m_b;
                p_wdata = r_i;
                if (r_i == m_top) begin
                    n_ready = 1'b1;
                end else begin
                    n_i      = r_i + IB'(1);
                    n_j      = IB'(1);
                    mctl.clr = 1'b1;
                end
            end
            S_WALK_RD: p_raddr = r_p;
            S_WALK_CHK: begin
                // fetch parent and right child of the next level together
                p_raddr = p_rdata;
                n_up    = p_rdata;
                if (p_rdata == '0 || r_len == LEN_BITS'(CODE_BITS)) begin
                    n_res.code_length = r_len;
                    {n_res.code_bits_3, n_res.code_bits_2,
                     n_res.code_bits_1, n_res.code_bits_0} = {1'b0, r_code};
                end
            end
            S_WALK_BIT: begin
                p_raddr = r_up;
                n_code  = {r_code[CODE_BITS-2:0], rt_rdata == r_p};
                n_len   = r_len + LEN_BITS'(1);
                n_p     = r_up;
            end
            S_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_ready   <= 1'b0;
            r_closed  <= 1'b0;
            r_ev      <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ready  <= n_ready;
            r_closed <= n_closed;
            r_ev     <= n_ev;
            if (r_state == S_DONE && out_free) r_out_vld <= 1'b1;
            else if (!i_out_stall) r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i    <= n_i;
        r_j    <= n_j;
        r_evj  <= r_j;
        r_p    <= n_p;
        r_up   <= n_up;
        r_len  <= n_len;
        r_code <= n_code;
        r_res  <= n_res;
        if (r_state == S_DONE && out_free) r_out <= r_res;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;
endmodule

FILE: sv/hfc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module hfc_ram #(
    parameter int W     = 32,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [W-1:0]             i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [W-1:0]             o_rdata
);
    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: sv/hfc_min2.sv
// Shared compare unit: tracks the two least-weight nodes seen in a scan.
// Depends on hfc_pkg.
`timescale 1ns / 1ps
module hfc_min2 #(
    parameter int IDX_BITS = 9
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  hfc_pkg::t_min2_ctl       i_ctl,
    input  logic [IDX_BITS-1:0]      i_idx,
    input  logic [hfc_pkg::NODE_W-1:0] i_weight,
    output logic [IDX_BITS-1:0]      o_a,
    output logic [IDX_BITS-1:0]      o_b,
    output logic [hfc_pkg::NODE_W-1:0] o_wa,
    output logic [hfc_pkg::NODE_W-1:0] o_wb
);
    import hfc_pkg::*;

    logic                r_av, r_bv;
    logic [IDX_BITS-1:0] r_a, r_b;
    logic [NODE_W-1:0]   r_wa, r_wb;

    // strict less-than keeps the lower index on ties
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            r_av <= 1'b0;
            r_bv <= 1'b0;
        end else if (i_ctl.ev) begin
            if (!r_av || i_weight < r_wa) begin
                r_b  <= r_a;
                r_wb <= r_wa;
                r_bv <= r_av;
                r_a  <= i_idx;
                r_wa <= i_weight;
                r_av <= 1'b1;
            end else if (!r_bv || i_weight < r_wb) begin
                r_b  <= i_idx;
                r_wb <= i_weight;
                r_bv <= 1'b1;
            end
        end
    end

    assign o_a  = r_a;
    assign o_b  = r_b;
    assign o_wa = r_wa;
    assign o_wb = r_wb;
endmodule

FILE: sv/hfc_checker.sv
// Port-level checker for the Huffman code unit, bound to the top level.
// Depends on hfc_pkg and huffman_tree_build_and_code_unit_defines.svh.
`timescale 1ns / 1ps
`include "huffman_tree_build_and_code_unit_defines.svh"
module hfc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input hfc_pkg::t_in_item  i_in,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input hfc_pkg::t_out_item o_out
);
    import hfc_pkg::*;

    // a stalled result transaction holds
    `HFC_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out))
    // error results carry no code
    `HFC_ASSERT_NOW(a_err_nocode, o_out_valid && o_out.status != ST_OK, o_out.code_length == 8'd0)
    // an accepted query always stalls the input in the following cycle
    `HFC_ASSERT_NEXT(a_query_busy, i_in_valid && !o_in_stall && i_in.cmd == CMD_QUERY, o_in_stall)
endmodule

bind huffman_tree_build_and_code_unit hfc_checker u_hfc_checker (.*);

FILE: verif/tb_top.sv
// Self-checking bench for huffman_tree_build_and_code_unit: weight sets, tree builds
// and code queries checked against a behavioral tree builder. Depends on hfc_pkg.
`timescale 1ns / 1ps
module tb_top;
    import hfc_pkg::*;

    localparam int NODES      = 512;
    localparam int TARGET     = 1900;
    localparam int IDLE_LIMIT = 400000;
    localparam int DRAIN      = 64;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;

    always #6 i_clk = ~i_clk;

    huffman_tree_build_and_code_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in       (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out      (out_item)
    );

    // ---------------------------------------------------------------
    // Behavioral tree model: node 0 means "none", leaves at 1..n, root 2n-1
    // ---------------------------------------------------------------
    bit [31:0] node_wt  [NODES];
    bit [8:0]  node_up  [NODES];
    bit [8:0]  node_lo  [NODES];
    bit [8:0]  node_hi  [NODES];
    int unsigned loaded_cnt = 0;
    bit        tree_valid = 1'b0;
    bit        set_done   = 1'b0;

    t_in_item  pending_items[$];
    t_out_item expected_codes[$];
    int        err_cnt = 0;
    int        n_builds = 0, n_queries = 0, n_errs_seen = 0, n_results = 0;

    // lightest parentless node among 1..top, ignoring skip; ties to lowest index
    function automatic int unsigned lightest_free(int unsigned top, int unsigned skip);
        int unsigned best;
        bit [31:0]   bw;
        best = 0;
        bw = '0;
        for (int unsigned j = 1; j <= top && j < NODES; j++) begin
            if (j == skip || node_up[j] != 0) continue;
            if (best == 0 || node_wt[j] < bw) begin
                best = j;
                bw = node_wt[j];
            end
        end
        return best;
    endfunction

    task automatic grow_tree(int unsigned n);
        int unsigned top_node;
        int unsigned a, b;
        top_node = 2 * n - 1;
        for (int unsigned i = 1; i <= top_node && i < NODES; i++) begin
            node_up[i] = '0;
            node_lo[i] = '0;
            node_hi[i] = '0;
            if (i > n) node_wt[i] = '0;
        end
        for (int unsigned i = n + 1; i <= top_node && i < NODES; i++) begin
            a = lightest_free(i - 1, 0);
            b = lightest_free(i - 1, a);
            node_up[a] = i[8:0];
            node_up[b] = i[8:0];
            node_lo[i] = a[8:0];
            node_hi[i] = b[8:0];
            node_wt[i] = node_wt[a] + node_wt[b];
        end
    endtask

    // applies one accepted transaction, queues its result if it makes one
    task automatic huffman_predict(input t_in_item it);
        t_out_item   r;
        bit [255:0]  bits;
        bit [254:0]  path;
        int unsigned len, p, up, guard;
        r = '0;
        bits = '0;
        path = '0;
        if (it.cmd == CMD_LOAD) begin
            if (set_done) begin
                set_done = 1'b0;
                tree_valid = 1'b0;
                loaded_cnt = 0;
            end
            if (loaded_cnt < MAX_SYMBOLS_DEF) begin
                node_wt[loaded_cnt + 1] = {8'd0, it.weight};
                loaded_cnt++;
            end else begin
                loaded_cnt = MAX_SYMBOLS_DEF + 1;
            end
            if (!it.last) return;
            set_done = 1'b1;
            if (loaded_cnt < 2) r.status = ST_FEW;
            else if (loaded_cnt > MAX_SYMBOLS_DEF) r.status = ST_MANY;
            else begin
                r.status = ST_OK;
                grow_tree(loaded_cnt);
                tree_valid = 1'b1;
                n_builds++;
            end
        end else if (!tree_valid || it.symbol >= loaded_cnt) begin
            r.status = ST_BADQ;
        end else begin
            // climb to the root, recording which side each step came from
            len = 0;
            guard = 0;
            p = it.symbol + 1;
            while (node_up[p] != 0 && guard < NODES && len < 255) begin
                up = node_up[p];
                path[len] = (node_hi[up] == p);
                len++;
                p = up;
                guard++;
            end
            // bit k is the branch at depth k, i.e. read the climb backwards
            for (int unsigned k = 0; k < len; k++) bits[k] = path[len - 1 - k];
            r.status      = ST_OK;
            r.code_length = len[7:0];
            r.code_bits_0 = bits[63:0];
            r.code_bits_1 = bits[127:64];
            r.code_bits_2 = bits[191:128];
            r.code_bits_3 = bits[255:192];
            n_queries++;
        end
        if (r.status != ST_OK) n_errs_seen++;
        expected_codes.push_back(r);
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        err_cnt++;
        $display("[%0t] MISMATCH %s: got %h, expected %h", $time, what, got, want);
    endtask

    // ---------------------------------------------------------------
    // Driver: bursts of transactions with random gaps; payload holds while stalled
    // ---------------------------------------------------------------
    int burst_left = 0, gap_left = 0;
    int in_accepted = 0;

    always @(posedge i_clk) begin
        bit       take, nv;
        t_in_item nd;
        take = 1'b0;
        nv = 1'b0;
        nd = in_item;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            take = in_valid && !in_stall;
            if (take) begin
                huffman_predict(in_item);
                in_accepted++;
            end
            if (!in_valid || take) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_items.size() > 0) begin
                    nv = 1'b1;
                    nd = pending_items.pop_front();
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        // half the bursts are followed by no gap at all
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                in_valid <= nv;
                if (nv) in_item <= nd;
            end
        end
    end

    // ---------------------------------------------------------------
    // Receiver stall: switches between free-running, light and heavy stalling
    // ---------------------------------------------------------------
    int stall_mode = 0, stall_span = 0;

    always @(posedge i_clk) begin
        if (stall_span == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_span = $urandom_range(20, 300);
        end else begin
            stall_span--;
        end
        case (stall_mode)
            0: begin
                out_stall <= 1'b0;
            end
            1: begin
                out_stall <= ($urandom_range(0, 3) == 0);
            end
            default: begin
                out_stall <= ($urandom_range(0, 3) != 0);
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Monitor: each result transaction against the oldest expectation
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && out_valid && !out_stall) begin
            n_results++;
            if (expected_codes.size() == 0) begin
                report_mismatch("unexpected result transaction, status",
                                64'(out_item.status), 64'(0));
            end else begin
                want = expected_codes.pop_front();
                if (out_item.status != want.status)
                    report_mismatch("status", 64'(out_item.status), 64'(want.status));
                if (out_item.code_length != want.code_length)
                    report_mismatch("code_length", 64'(out_item.code_length),
                                    64'(want.code_length));
                if (out_item.code_bits_0 != want.code_bits_0)
                    report_mismatch("code_bits_0", out_item.code_bits_0, want.code_bits_0);
                if (out_item.code_bits_1 != want.code_bits_1)
                    report_mismatch("code_bits_1", out_item.code_bits_1, want.code_bits_1);
                if (out_item.code_bits_2 != want.code_bits_2)
                    report_mismatch("code_bits_2", out_item.code_bits_2, want.code_bits_2);
                if (out_item.code_bits_3 != want.code_bits_3)
                    report_mismatch("code_bits_3", out_item.code_bits_3, want.code_bits_3);
            end
        end
    end

    // Watchdog: cycles with no transaction on either side
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
            $display("huffman_tree_build_and_code_unit regression: fail");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    int queued = 0;

    task automatic push_load(logic [23:0] w, bit is_last);
        t_in_item it;
        it.cmd    = CMD_LOAD;
        it.weight = w;
        it.last   = is_last;
        it.symbol = 8'($urandom);  // ignored on loads
        pending_items.push_back(it);
        queued++;
    endtask

    task automatic push_query(logic [7:0] sym);
        t_in_item it;
        it.cmd    = CMD_QUERY;
        it.weight = 24'($urandom);  // ignored on queries
        it.last   = 1'($urandom);
        it.symbol = sym;
        pending_items.push_back(it);
        queued++;
    endtask

    // weight flavor: 0 full range, 1 tiny (many ties), 2 steep (deep trees)
    function automatic logic [23:0] pick_weight(int flavor, int idx);
        case (flavor)
            0: return 24'($urandom);
            1: return 24'($urandom_range(0, 3));
            default: return 24'(1 << (idx % 24)) | 24'($urandom_range(0, 1));
        endcase
    endfunction

    task automatic push_set(int n, int n_q, bit mid_query);
        int flavor;
        flavor = $urandom_range(0, 2);
        for (int i = 0; i < n; i++) begin
            // a query inside an open set sees no tree
            if (mid_query && i == n / 2) push_query(8'($urandom_range(0, 3)));
            push_load(pick_weight(flavor, i), i == n - 1);
        end
        for (int q = 0; q < n_q; q++) begin
            if ($urandom_range(0, 9) == 0) push_query(8'($urandom));
            else push_query(8'($urandom_range(0, n)));  // includes one past the end
        end
    endtask

    initial begin
        int n;
        // directed: query before any tree, single-symbol set, extremes, ties
        push_query(8'd0);
        push_load(24'hFFFFFF, 1'b1);
        push_query(8'd0);
        push_load(24'hFFFFFF, 1'b0);
        push_load(24'h000000, 1'b1);
        push_query(8'd0);
        push_query(8'd1);
        push_query(8'd2);
        push_query(8'd255);
        push_load(24'd5, 1'b0);
        push_load(24'd5, 1'b0);
        push_load(24'd5, 1'b0);
        push_load(24'd5, 1'b1);
        for (int s = 0; s < 4; s++) push_query(8'(s));
        push_load(24'h800000, 1'b0);
        push_load(24'h7FFFFF, 1'b0);
        push_load(24'h000001, 1'b1);
        for (int s = 0; s < 3; s++) push_query(8'(s));

        // random: mostly small sets, one full alphabet, one overflowing set
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (queued < TARGET) begin
            if (queued > 400 && queued < 420) begin
                push_set(MAX_SYMBOLS_DEF, 6, 1'b0);
                push_query(8'd255);
            end else if (queued > 1000 && queued < 1030) begin
                push_set(MAX_SYMBOLS_DEF + 3, 2, 1'b0);
            end else begin
                case ($urandom_range(0, 19))
                    0: n = 1;
                    1, 2: n = $urandom_range(17, 48);
                    default: n = $urandom_range(2, 16);
                endcase
                push_set(n, $urandom_range(0, 8), $urandom_range(0, 19) == 0);
            end
        end

        while (pending_items.size() != 0 || in_valid) @(posedge i_clk);
        while (expected_codes.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        $display("covered %0d transactions in, %0d results: %0d trees built, %0d codes read,",
                 in_accepted, n_results, n_builds, n_queries);
        $display("and %0d error statuses (small set, oversized set, bad query)", n_errs_seen);
        if (err_cnt == 0 && expected_codes.size() == 0) begin
            $display("huffman_tree_build_and_code_unit regression: pass");
        end else begin
            $display("huffman_tree_build_and_code_unit regression: fail");
        end
        $finish;
    end
endmodule
